>>> src/tcst_pkg.sv
// Shared types and constants for the touchpad contact slot tracker.
`timescale 1ns / 1ps
package tcst_pkg;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned MAJOR_W  = 8;
  localparam int unsigned FINGER_W = 48;
  localparam int unsigned FINGERS  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 176;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 4;

  localparam logic [POS_W-1:0] PAD_WIDTH_RESET  = 16'd1560;
  localparam logic [POS_W-1:0] PAD_HEIGHT_RESET = 16'd820;
  localparam logic [15:0] NOISE_STATUS = 16'h0003;
  localparam logic [7:0]  NOISE_COUNT  = 8'h05;
  localparam int unsigned ST_PT_EXIST_BIT     = 11;
  localparam int unsigned ST_BUTTON_EVENT_BIT = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAD_WIDTH  = 2'd0,
    REG_PAD_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    OP_FRAME       = 1'b0,
    OP_RELEASE_ALL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_POSITION = 2'd1,
    ACT_RELEASED = 2'd2
  } action_t;

  typedef struct packed {
    logic [7:0]       contact_flags;
    logic [7:0]       width;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] x;
  } finger_t;

  typedef struct packed {
    action_t            action;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [MAJOR_W-1:0] touch_major;
  } lane_res_t;

  typedef struct packed {
    logic report;
    logic down;
  } button_t;

endpackage

>>> src/tcst_lane.sv
// One contact slot lane: existence, bound check, axis transform and slot memory update.
`timescale 1ns / 1ps
module tcst_lane (
  input  logic                        op,
  input  logic                        pt_exist,
  input  logic                        was_active,
  input  logic [tcst_pkg::POS_W-1:0]  pad_width,
  input  logic [tcst_pkg::POS_W-1:0]  pad_height,
  input  tcst_pkg::finger_t           finger,
  output tcst_pkg::lane_res_t         res,
  output logic                        active_next
);
  import tcst_pkg::*;

  logic exists;
  logic in_bounds;

  assign exists    = pt_exist & finger.contact_flags[0];
  assign in_bounds = (finger.x < pad_width) && (finger.y < pad_height);

  always_comb begin
    res         = '0;
    res.action  = ACT_NONE;
    active_next = was_active;
    if (op == OP_RELEASE_ALL) begin
      res.action  = ACT_RELEASED;
      active_next = 1'b0;
    end else if (exists) begin
      if (in_bounds) begin
        res.action      = ACT_POSITION;
        res.pos_x       = pad_height - POS_W'(1) - finger.y;
        res.pos_y       = finger.x;
        res.touch_major = (finger.width != '0) ? finger.width : MAJOR_W'(1);
        active_next     = 1'b1;
      end
    end else begin
      if (was_active) begin
        res.action = ACT_RELEASED;
      end
      active_next = 1'b0;
    end
  end

endmodule

>>> src/tcst_merge.sv
// Result bank holding every lane's result and sending them out in slot order.
`timescale 1ns / 1ps
module tcst_merge #(
  parameter int unsigned NLANE = 3
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     load,
  input  tcst_pkg::lane_res_t [NLANE-1:0]          lane_res,
  input  tcst_pkg::button_t                        button,
  output logic                                     free,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [tcst_pkg::OUT_DATA_W-1:0]          m_tdata,  // pos_x, pos_y, touch_major, button_report, button_down, pad
  output logic [tcst_pkg::OUT_USER_W-1:0]          m_tuser,  // slot, action
  output logic                                     m_tlast
);
  import tcst_pkg::*;

  localparam int unsigned IDX_W = (NLANE > 1) ? $clog2(NLANE) : 1;

  lane_res_t [NLANE-1:0] bank;
  button_t               btn;
  logic [IDX_W-1:0]      idx;
  logic                  busy;
  logic                  is_last;
  logic                  take;
  logic                  done;
  lane_res_t             cur;
  button_t               cur_btn;

  assign is_last = (idx == IDX_W'(NLANE - 1));
  assign take    = busy & m_tready;
  assign done    = take & is_last;
  assign free    = ~busy | done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (done) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bank <= lane_res;
      btn  <= button;
    end
  end

  always_comb begin
    cur     = bank[idx];
    cur_btn = is_last ? btn : '0;
  end

  assign m_tvalid = busy;
  assign m_tlast  = is_last;
  assign m_tuser  = {cur.action, 2'(idx)};
  assign m_tdata  = {6'd0, cur_btn.down, cur_btn.report, cur.touch_major,
                     cur.pos_y, cur.pos_x};

endmodule

>>> src/touchpad_contact_slot_tracker_top.sv
// Top level of the touchpad contact slot tracker: config registers, slot lanes, result bank.
// Results of a frame appear in the cycle after its transfer; the result bank drains one slot
// per cycle while m_tready is high and takes the next frame in the cycle its last result is
// transferred.
// A noise frame is taken and gives no result.
// Reset (rst, synchronous): pad size back to 1560 x 820, all slots inactive, bank empty.
`timescale 1ns / 1ps
module touchpad_contact_slot_tracker_top #(
  parameter int unsigned SLOTS = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tcst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcst_pkg::POS_W-1:0]          cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tcst_pkg::IN_DATA_W-1:0]      s_tdata,  // status, count, button, fingers 0..2
  input  logic                                s_tuser,  // operation
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tcst_pkg::OUT_DATA_W-1:0]     m_tdata,  // pos_x, pos_y, major, btn rpt/down, pad
  output logic [tcst_pkg::OUT_USER_W-1:0]     m_tuser,  // slot, action
  output logic                                m_tlast
);
  import tcst_pkg::*;

  localparam int unsigned NLANE = (SLOTS < FINGERS) ? SLOTS : FINGERS;

  logic [POS_W-1:0]      pad_width;
  logic [POS_W-1:0]      pad_height;
  logic [NLANE-1:0]      slot_active;
  logic [NLANE-1:0]      slot_active_next;
  lane_res_t [NLANE-1:0] lane_res;
  finger_t [FINGERS-1:0] fingers;
  button_t               button;
  logic [15:0]           frame_status;
  logic [7:0]            finger_count;
  logic [7:0]            button_byte;
  logic                  noise;
  logic                  accept;
  logic                  load;
  logic                  free;

  assign frame_status = s_tdata[15:0];
  assign finger_count = s_tdata[23:16];
  assign button_byte  = s_tdata[31:24];
  assign fingers      = s_tdata[IN_DATA_W-1:32];

  assign noise  = (s_tuser == OP_FRAME) && (frame_status == NOISE_STATUS) &&
                  (finger_count == NOISE_COUNT);
  assign s_tready = free;
  assign accept   = s_tvalid & s_tready;
  assign load     = accept & ~noise;

  always_comb begin
    if (s_tuser == OP_RELEASE_ALL) begin
      button.report = 1'b1;
      button.down   = 1'b0;
    end else begin
      button.report = frame_status[ST_BUTTON_EVENT_BIT];
      button.down   = frame_status[ST_BUTTON_EVENT_BIT] & button_byte[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_width  <= PAD_WIDTH_RESET;
      pad_height <= PAD_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAD_WIDTH:  pad_width  <= cfg_data;
        REG_PAD_HEIGHT: pad_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
    end else if (load) begin
      slot_active <= slot_active_next;
    end
  end

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    tcst_lane u_lane (
      .op          (s_tuser),
      .pt_exist    (frame_status[ST_PT_EXIST_BIT]),
      .was_active  (slot_active[i]),
      .pad_width   (pad_width),
      .pad_height  (pad_height),
      .finger      (fingers[i]),
      .res         (lane_res[i]),
      .active_next (slot_active_next[i])
    );
  end

  tcst_merge #(
    .NLANE (NLANE)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .lane_res (lane_res),
    .button   (button),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty result bank");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser[1:0] == 2'(NLANE - 1)))
    else $error("last result not on final slot");

  a_major_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[3:2] == ACT_POSITION)) |-> (m_tdata[39:32] != '0))
    else $error("position reported with zero width");

  a_frame_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && !s_tready ||
      m_tvalid && m_tlast))
    else $error("frame results broken before last slot");

endmodule
